/* rtl/sha_pow_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 proof-of-work package
// Shared types, round constants and helper functions.
// ----------------------------------------------------------------------------
package sha_pow_pkg;

  localparam int unsigned ProofW    = 31;
  localparam int unsigned CountW    = 32;
  localparam int unsigned NibW      = 4;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned MaxDigits = 10;

  localparam logic [CfgIdxW-1:0] CfgZeroNibbles = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxAttempts = 1'b1;

  localparam logic [ProofW:0] SumLimit = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StConv,
    StLoad,
    StRound,
    StTest,
    StDone
  } state_e;

  typedef logic [31:0] word_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t kround(input logic [5:0] r);
    case (r)
      6'd0:  kround = 32'h428a2f98; 6'd1:  kround = 32'h71374491;
      6'd2:  kround = 32'hb5c0fbcf; 6'd3:  kround = 32'he9b5dba5;
      6'd4:  kround = 32'h3956c25b; 6'd5:  kround = 32'h59f111f1;
      6'd6:  kround = 32'h923f82a4; 6'd7:  kround = 32'hab1c5ed5;
      6'd8:  kround = 32'hd807aa98; 6'd9:  kround = 32'h12835b01;
      6'd10: kround = 32'h243185be; 6'd11: kround = 32'h550c7dc3;
      6'd12: kround = 32'h72be5d74; 6'd13: kround = 32'h80deb1fe;
      6'd14: kround = 32'h9bdc06a7; 6'd15: kround = 32'hc19bf174;
      6'd16: kround = 32'he49b69c1; 6'd17: kround = 32'hefbe4786;
      6'd18: kround = 32'h0fc19dc6; 6'd19: kround = 32'h240ca1cc;
      6'd20: kround = 32'h2de92c6f; 6'd21: kround = 32'h4a7484aa;
      6'd22: kround = 32'h5cb0a9dc; 6'd23: kround = 32'h76f988da;
      6'd24: kround = 32'h983e5152; 6'd25: kround = 32'ha831c66d;
      6'd26: kround = 32'hb00327c8; 6'd27: kround = 32'hbf597fc7;
      6'd28: kround = 32'hc6e00bf3; 6'd29: kround = 32'hd5a79147;
      6'd30: kround = 32'h06ca6351; 6'd31: kround = 32'h14292967;
      6'd32: kround = 32'h27b70a85; 6'd33: kround = 32'h2e1b2138;
      6'd34: kround = 32'h4d2c6dfc; 6'd35: kround = 32'h53380d13;
      6'd36: kround = 32'h650a7354; 6'd37: kround = 32'h766a0abb;
      6'd38: kround = 32'h81c2c92e; 6'd39: kround = 32'h92722c85;
      6'd40: kround = 32'ha2bfe8a1; 6'd41: kround = 32'ha81a664b;
      6'd42: kround = 32'hc24b8b70; 6'd43: kround = 32'hc76c51a3;
      6'd44: kround = 32'hd192e819; 6'd45: kround = 32'hd6990624;
      6'd46: kround = 32'hf40e3585; 6'd47: kround = 32'h106aa070;
      6'd48: kround = 32'h19a4c116; 6'd49: kround = 32'h1e376c08;
      6'd50: kround = 32'h2748774c; 6'd51: kround = 32'h34b0bcb5;
      6'd52: kround = 32'h391c0cb3; 6'd53: kround = 32'h4ed8aa4a;
      6'd54: kround = 32'h5b9cca4f; 6'd55: kround = 32'h682e6ff3;
      6'd56: kround = 32'h748f82ee; 6'd57: kround = 32'h78a5636f;
      6'd58: kround = 32'h84c87814; 6'd59: kround = 32'h8cc70208;
      6'd60: kround = 32'h90befffa; 6'd61: kround = 32'ha4506ceb;
      6'd62: kround = 32'hbef9a3f7; default: kround = 32'hc67178f2;
    endcase
  endfunction

  function automatic word_t hinit(input logic [2:0] i);
    case (i)
      3'd0: hinit = 32'h6a09e667; 3'd1: hinit = 32'hbb67ae85;
      3'd2: hinit = 32'h3c6ef372; 3'd3: hinit = 32'ha54ff53a;
      3'd4: hinit = 32'h510e527f; 3'd5: hinit = 32'h9b05688c;
      3'd6: hinit = 32'h1f83d9ab; default: hinit = 32'h5be0cd19;
    endcase
  endfunction

endpackage

/* rtl/sha_pow_if.sv */
// ----------------------------------------------------------------------------
// Stream channel interfaces
// Valid/ready channels for search requests, results and register writes.
// ----------------------------------------------------------------------------
interface sha_pow_req_if;
  logic                           valid;
  logic                           ready;
  logic [sha_pow_pkg::ProofW-1:0] prior_proof;
  modport source (output valid, prior_proof, input ready);
  modport sink (input valid, prior_proof, output ready);
endinterface

interface sha_pow_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sha_pow_pkg::ProofW-1:0] found_proof;
  logic                           found;
  logic [sha_pow_pkg::CountW-1:0] attempts_used;
  modport source (output valid, found_proof, found, attempts_used, input ready);
  modport sink (input valid, found_proof, found, attempts_used, output ready);
endinterface

interface sha_pow_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sha_pow_pkg::CfgIdxW-1:0]  index;
  logic [sha_pow_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/sha256_proof_of_work_search.sv */
// ----------------------------------------------------------------------------
// SHA-256 proof-of-work search
// Tries candidates 1, 2, ... hashing the decimal form of candidate plus the
// prior proof, until the digest has enough leading zero nibbles.
// Each attempt runs a check, the digit conversion digit by digit, a block
// load, 64 rounds in a single round unit and a digest test. The result beat
// is registered in the done state, also when the search gives up, once the
// prior result beat has left. The next request is taken once the sequencer
// is idle and no register write is pending.
// Reset clears the sequencer, the registers to their defaults and the output.
// ----------------------------------------------------------------------------
module sha256_proof_of_work_search (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha_pow_req_if.sink   req,
  sha_pow_rsp_if.source rsp,
  sha_pow_cfg_if.sink   cfg
);

  sha_pow_pkg::state_e state_q, state_d;

  logic [sha_pow_pkg::NibW-1:0]    zero_nib_q;
  logic [sha_pow_pkg::CountW-1:0]  max_att_q;
  logic [sha_pow_pkg::ProofW-1:0]  prior_q;
  logic [sha_pow_pkg::ProofW-1:0]  cand_q;
  logic [sha_pow_pkg::CountW-1:0]  att_q;
  logic                            found_q;
  logic [sha_pow_pkg::ProofW:0]    val_q;
  logic [3:0]                      len_q;
  logic [3:0]                      digit_q [sha_pow_pkg::MaxDigits];
  sha_pow_pkg::word_t              wv_q [8];
  sha_pow_pkg::word_t              w_q [16];
  logic [6:0]                      rnd_q;
  logic                            rsp_valid_q;
  logic [sha_pow_pkg::ProofW-1:0]  rsp_proof_q;
  logic                            rsp_found_q;
  logic [sha_pow_pkg::CountW-1:0]  rsp_att_q;

  logic [sha_pow_pkg::ProofW:0] sum;
  logic [sha_pow_pkg::ProofW:0] quot;
  logic [63:0]                  qprod;
  logic [3:0]                   rem;
  logic [5:0]                   r6;
  sha_pow_pkg::word_t           w15, w2, wnew, wcur, s0, s1, ch, mj, t1, t2;
  sha_pow_pkg::word_t           dig0, dig1;
  logic                         pass;
  logic                         rsp_free;
  logic [7:0]                   blk [64];

  assign cfg.ready = (state_q == sha_pow_pkg::StIdle);
  assign req.ready = (state_q == sha_pow_pkg::StIdle) && !cfg.valid;
  assign rsp.valid = rsp_valid_q;
  assign rsp.found_proof = rsp_proof_q;
  assign rsp.found = rsp_found_q;
  assign rsp.attempts_used = rsp_att_q;
  assign rsp_free = !rsp_valid_q || rsp.ready;

  assign sum   = {1'b0, cand_q} + {1'b0, prior_q};
  assign qprod = {32'd0, val_q} * 64'hCCCC_CCCD;
  assign quot  = {3'b000, qprod[63:35]};
  assign rem   = 4'(val_q - (quot * 32'd10));
  assign r6    = rnd_q[5:0];

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      blk[i] = 8'h00;
    end
    for (int i = 0; i < sha_pow_pkg::MaxDigits; i++) begin
      if (4'(i) < len_q) begin
        blk[i] = {4'h3, digit_q[4'(len_q - 4'(i) - 4'd1)]};
      end else if (4'(i) == len_q) begin
        blk[i] = 8'h80;
      end
    end
    if (len_q == 4'd10) begin
      blk[10] = 8'h80;
    end
    blk[63] = {len_q, 3'b000} + 8'd0;
  end

  always_comb begin
    w15  = w_q[4'(r6 - 6'd15)];
    w2   = w_q[4'(r6 - 6'd2)];
    wnew = w_q[r6[3:0]]
         + (sha_pow_pkg::rotr(w15, 7) ^ sha_pow_pkg::rotr(w15, 18) ^ (w15 >> 3))
         + w_q[4'(r6 - 6'd7)]
         + (sha_pow_pkg::rotr(w2, 17) ^ sha_pow_pkg::rotr(w2, 19) ^ (w2 >> 10));
    wcur = (r6 < 6'd16) ? w_q[r6[3:0]] : wnew;
    s1 = sha_pow_pkg::rotr(wv_q[4], 6) ^ sha_pow_pkg::rotr(wv_q[4], 11)
       ^ sha_pow_pkg::rotr(wv_q[4], 25);
    ch = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
    t1 = wv_q[7] + s1 + ch + sha_pow_pkg::kround(r6) + wcur;
    s0 = sha_pow_pkg::rotr(wv_q[0], 2) ^ sha_pow_pkg::rotr(wv_q[0], 13)
       ^ sha_pow_pkg::rotr(wv_q[0], 22);
    mj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
    t2 = s0 + mj;
  end

  always_comb begin
    dig0 = sha_pow_pkg::hinit(3'd0) + wv_q[0];
    dig1 = sha_pow_pkg::hinit(3'd1) + wv_q[1];
    pass = 1'b1;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < {1'b0, zero_nib_q}) begin
        if (i < 8) begin
          if (dig0[31 - 4 * i -: 4] != 4'h0) pass = 1'b0;
        end else begin
          if (dig1[31 - 4 * (i - 8) -: 4] != 4'h0) pass = 1'b0;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sha_pow_pkg::StIdle: begin
        if (req.valid && req.ready) state_d = sha_pow_pkg::StCheck;
      end
      sha_pow_pkg::StCheck: begin
        if (att_q >= max_att_q || sum > sha_pow_pkg::SumLimit) begin
          state_d = sha_pow_pkg::StDone;
        end else begin
          state_d = sha_pow_pkg::StConv;
        end
      end
      sha_pow_pkg::StConv: begin
        if (quot == '0 || len_q == 4'd9) state_d = sha_pow_pkg::StLoad;
      end
      sha_pow_pkg::StLoad: state_d = sha_pow_pkg::StRound;
      sha_pow_pkg::StRound: begin
        if (rnd_q == 7'd63) state_d = sha_pow_pkg::StTest;
      end
      sha_pow_pkg::StTest: begin
        state_d = pass ? sha_pow_pkg::StDone : sha_pow_pkg::StCheck;
      end
      sha_pow_pkg::StDone: begin
        if (rsp_free) state_d = sha_pow_pkg::StIdle;
      end
      default: state_d = sha_pow_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pow_pkg::StIdle;
      zero_nib_q <= 4'd1;
      max_att_q <= 32'd1048576;
      rsp_valid_q <= 1'b0;
      att_q <= '0;
      cand_q <= '0;
      rnd_q <= '0;
      found_q <= 1'b0;
      rsp_found_q <= 1'b0;
      rsp_proof_q <= '0;
      rsp_att_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          sha_pow_pkg::CfgZeroNibbles: zero_nib_q <= cfg.data[3:0];
          sha_pow_pkg::CfgMaxAttempts: max_att_q <= cfg.data;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) rsp_valid_q <= 1'b0;
      case (state_q)
        sha_pow_pkg::StIdle: begin
          if (req.valid && req.ready) begin
            prior_q <= req.prior_proof;
            cand_q <= 31'd1;
            att_q <= '0;
            found_q <= 1'b0;
          end
        end
        sha_pow_pkg::StCheck: begin
          val_q <= sum;
          len_q <= 4'd0;
          rnd_q <= '0;
        end
        sha_pow_pkg::StConv: begin
          digit_q[len_q] <= rem;
          val_q <= quot;
          len_q <= len_q + 4'd1;
        end
        sha_pow_pkg::StLoad: begin
          for (int i = 0; i < 16; i++) begin
            w_q[i] <= {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
          end
          for (int i = 0; i < 8; i++) begin
            wv_q[i] <= sha_pow_pkg::hinit(3'(i));
          end
        end
        sha_pow_pkg::StRound: begin
          if (r6 >= 6'd16) w_q[r6[3:0]] <= wnew;
          wv_q[7] <= wv_q[6];
          wv_q[6] <= wv_q[5];
          wv_q[5] <= wv_q[4];
          wv_q[4] <= wv_q[3] + t1;
          wv_q[3] <= wv_q[2];
          wv_q[2] <= wv_q[1];
          wv_q[1] <= wv_q[0];
          wv_q[0] <= t1 + t2;
          rnd_q <= rnd_q + 7'd1;
        end
        sha_pow_pkg::StTest: begin
          att_q <= att_q + 32'd1;
          if (pass) found_q <= 1'b1;
          else cand_q <= cand_q + 31'd1;
        end
        sha_pow_pkg::StDone: begin
          if (rsp_free) begin
            rsp_valid_q <= 1'b1;
            rsp_proof_q <= found_q ? cand_q : '0;
            rsp_found_q <= found_q;
            rsp_att_q <= att_q;
          end
        end
        default: ;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sha_pow_pkg::StIdle) |-> !req.ready)
    else $error("request taken while busy");
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha_pow_pkg::StRound) |-> (rnd_q < 7'd64))
    else $error("round index out of range");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha_pow_pkg::StDone) |=> rsp_valid_q)
    else $error("result not presented");
  a_att_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_att_q <= max_att_q))
    else $error("attempt count over limit");

endmodule
